### design/anbs_pkg.sv
// Shared widths, result item layout and queue interface types for the NAL unit splitter.
package anbs_pkg;

   localparam longint unsigned MAX_BUFFER_BYTES = 64'd16777216;
   localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 64'd1);

   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 24;
   localparam int SIZE_W   = 25;
   localparam int PREFIX_W = 2;
   localparam int LIMIT_W  = 8;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd16;

   localparam logic [PREFIX_W-1:0] PRE_NONE  = 2'd0;
   localparam logic [PREFIX_W-1:0] PRE_THREE = 2'd1;
   localparam logic [PREFIX_W-1:0] PRE_FOUR  = 2'd2;

   // power of two, at least 2
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [OFFSET_W-1:0] unit_offset;
      logic [SIZE_W-1:0]   unit_size;
      logic [PREFIX_W-1:0] prefix_length;
      logic                last_unit;
      logic                limit_hit;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic nonempty;
      logic almost_full;
   } fifo_status_type;

endpackage

### design/annexb_nal_unit_splitter.sv
// Top level of the Annex B NAL unit splitter.
// Bytes of an Annex B buffer enter on the req_ channel, one item per byte, with
// req_end_of_buffer set on the last byte. An item is taken on a clock edge with
// req_valid high and req_stall low. Each NAL unit found comes out on the rsp_
// channel as one item: payload offset, payload size, stripped prefix code,
// last_unit and limit_hit flags. A byte yields zero, one or two result items.
// Throughput is one byte per cycle while req_stall is low. A result item is
// written into a four-entry queue at the edge that takes its byte, then moves to
// the output register once it heads the queue and that register is free.
// req_stall goes high while fewer than two queue entries are free, which only
// happens when rsp_stall holds results back. csr_unit_limit is written through
// the csr_ channel, always ready, and is to be changed only while idle.
// Reset is synchronous: it empties the queue, drops rsp_valid, clears the
// per-buffer state and sets unit_limit to 16. req_stall is high during reset.
module annexb_nal_unit_splitter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [anbs_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                              req_end_of_buffer,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [anbs_pkg::OFFSET_W-1:0]     rsp_unit_offset,
   output logic [anbs_pkg::SIZE_W-1:0]       rsp_unit_size,
   output logic [anbs_pkg::PREFIX_W-1:0]     rsp_prefix_length,
   output logic                              rsp_last_unit,
   output logic                              rsp_limit_hit,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [anbs_pkg::LIMIT_W-1:0]      csr_unit_limit
);
   import anbs_pkg::*;

   push_type        push;
   fifo_status_type status;
   result_type      head;
   result_type      rsp_item;
   logic            pop;
   logic            req_accept;

   assign req_stall  = status.almost_full || reset;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   anbs_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .data_byte      (req_data_byte),
      .end_of_buffer  (req_end_of_buffer),
      .csr_valid      (csr_valid && csr_ready),
      .csr_unit_limit (csr_unit_limit),
      .push           (push)
   );

   anbs_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (status)
   );

   anbs_out u_out (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .rsp_stall (rsp_stall),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign rsp_unit_offset   = rsp_item.unit_offset;
   assign rsp_unit_size     = rsp_item.unit_size;
   assign rsp_prefix_length = rsp_item.prefix_length;
   assign rsp_last_unit     = rsp_item.last_unit;
   assign rsp_limit_hit     = rsp_item.limit_hit;

   // two items from one byte only when the buffer closes on it
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && push.count == 2'd2) |-> req_end_of_buffer)
      else $error("two result items without buffer end");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> status.nonempty)
      else $error("queue read while empty");

   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |=> status.nonempty)
      else $error("queue empty after a write");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_limit_hit || rsp_last_unit))
      else $error("limit_hit on a unit not flagged last");

endmodule

### design/anbs_parser.sv
// Front end: start code scan over the byte window, unit bookkeeping and result item generation.
module anbs_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [anbs_pkg::BYTE_W-1:0]  data_byte,
   input  logic                         end_of_buffer,
   input  logic                         csr_valid,
   input  logic [anbs_pkg::LIMIT_W-1:0] csr_unit_limit,
   output anbs_pkg::push_type           push
);
   import anbs_pkg::*;

   localparam int HIST_BYTES   = 3;
   localparam int WIN_BYTES    = 4;
   localparam int SETTLE_STEPS = 5;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BUFFER_BYTES);

   typedef enum logic [2:0] {
      PH_PREFIX = 3'b001,
      PH_BODY   = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   logic [LIMIT_W-1:0]             limit_ff;
   logic [HIST_BYTES*BYTE_W-1:0]   hist_ff, hist_in;
   logic [1:0]                     hist_cnt_ff, hist_cnt_in;
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [POS_W-1:0]               start_ff, start_in;
   phase_type                      phase_ff, phase_in;
   logic [LIMIT_W-1:0]             units_ff, units_in;
   logic [PREFIX_W-1:0]            pre_ff, pre_in;

   logic [WIN_BYTES*BYTE_W-1:0]    win;
   logic [2:0]                     cnt;
   logic                           take;
   logic                           stop;
   logic                           emit;
   logic [2:0]                     emit_back;
   logic                           at_limit;
   logic                           start_set;
   logic [2:0]                     start_back;
   logic [POS_W-1:0]               emit_end;
   logic                           fin_valid;
   result_type                     emit_rec, fin_rec;

   always_comb begin
      win         = {BYTE_W'(0), hist_ff};
      cnt         = {1'b0, hist_cnt_ff};
      phase_in    = phase_ff;
      units_in    = units_ff;
      pre_in      = pre_ff;
      emit        = 1'b0;
      emit_back   = 3'd0;
      at_limit    = 1'b0;
      start_set   = 1'b0;
      start_back  = 3'd0;

      if (phase_in != PH_DONE && units_ff >= limit_ff) begin
         phase_in = PH_DONE;
         cnt      = 3'd0;
      end
      take   = accept && phase_in != PH_DONE && pos_ff < POS_MAX;
      pos_in = pos_ff + POS_W'(take);
      if (take) begin
         win[cnt[1:0]*BYTE_W +: BYTE_W] = data_byte;
         cnt = cnt + 3'd1;
      end

      stop = !take;
      for (int it = 0; it < SETTLE_STEPS; it++) begin
         if (!stop) begin
            case (phase_in)
               PH_PREFIX: begin
                  if ((cnt >= 3'd1 && win[7:0] != 8'd0) ||
                      (cnt >= 3'd2 && win[15:8] != 8'd0)) begin
                     start_set  = 1'b1;
                     start_back = cnt;
                     pre_in     = PRE_NONE;
                     phase_in   = PH_BODY;
                  end else if (cnt < 3'd3) begin
                     stop = 1'b1;
                  end else if (win[23:16] == 8'd1) begin
                     win        = win >> (3 * BYTE_W);
                     cnt        = cnt - 3'd3;
                     start_set  = 1'b1;
                     start_back = cnt;
                     pre_in     = PRE_THREE;
                     phase_in   = PH_BODY;
                  end else if (win[23:16] > 8'd1) begin
                     start_set  = 1'b1;
                     start_back = cnt;
                     pre_in     = PRE_NONE;
                     phase_in   = PH_BODY;
                  end else if (cnt < 3'd4) begin
                     stop = 1'b1;
                  end else if (win[31:24] == 8'd1) begin
                     win        = win >> (4 * BYTE_W);
                     cnt        = 3'd0;
                     start_set  = 1'b1;
                     start_back = 3'd0;
                     pre_in     = PRE_FOUR;
                     phase_in   = PH_BODY;
                  end else begin
                     // leading zero of a zero run: skip it
                     win = win >> BYTE_W;
                     cnt = cnt - 3'd1;
                  end
               end
               PH_BODY: begin
                  if (cnt < 3'd3) begin
                     stop = 1'b1;
                  end else if (win[7:0] == 8'd0 && win[15:8] == 8'd0 &&
                               win[23:16] <= 8'd1) begin
                     emit      = 1'b1;
                     emit_back = cnt;
                     at_limit  = ({1'b0, units_in} + 9'd1) >= {1'b0, limit_ff};
                     units_in  = units_in + 8'd1;
                     if (at_limit) begin
                        phase_in = PH_DONE;
                        cnt      = 3'd0;
                        stop     = 1'b1;
                     end else begin
                        phase_in = PH_PREFIX;
                     end
                  end else begin
                     win = win >> BYTE_W;
                     cnt = cnt - 3'd1;
                  end
               end
               default: begin
                  cnt  = 3'd0;
                  stop = 1'b1;
               end
            endcase
         end
      end

      start_in = start_set ? pos_in - POS_W'(start_back) : start_ff;

      // a unit closed in this step was opened in an earlier one
      emit_end               = pos_in - POS_W'(emit_back);
      emit_rec.unit_offset   = OFFSET_W'(start_ff);
      emit_rec.unit_size     = SIZE_W'(emit_end - start_ff);
      emit_rec.prefix_length = pre_ff;
      emit_rec.last_unit     = at_limit;
      emit_rec.limit_hit     = at_limit;

      fin_valid              = 1'b0;
      fin_rec.unit_offset    = OFFSET_W'(start_in);
      fin_rec.unit_size      = SIZE_W'(pos_in - start_in);
      fin_rec.prefix_length  = pre_in;
      fin_rec.last_unit      = 1'b1;
      fin_rec.limit_hit      = 1'b0;
      if (accept && end_of_buffer) begin
         case (phase_in)
            PH_PREFIX: begin
               if (cnt == 3'd3) begin
                  // zero run at buffer end keeps two zero bytes
                  fin_valid           = 1'b1;
                  fin_rec.unit_offset = OFFSET_W'(pos_in - POS_W'(2));
                  fin_rec.unit_size   = SIZE_W'(2);
                  fin_rec.prefix_length = PRE_NONE;
               end else if (cnt != 3'd0) begin
                  fin_valid           = 1'b1;
                  fin_rec.unit_offset = OFFSET_W'(pos_in - POS_W'(cnt));
                  fin_rec.unit_size   = SIZE_W'(cnt);
                  fin_rec.prefix_length = PRE_NONE;
               end
            end
            PH_BODY: fin_valid = 1'b1;
            default: fin_valid = 1'b0;
         endcase
      end

      hist_in     = win[HIST_BYTES*BYTE_W-1:0];
      hist_cnt_in = cnt[1:0];

      push.count  = 2'(emit) + 2'(fin_valid);
      push.first  = emit ? emit_rec : fin_rec;
      push.second = fin_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_RESET;
         hist_ff     <= '0;
         hist_cnt_ff <= 2'd0;
         pos_ff      <= '0;
         start_ff    <= '0;
         phase_ff    <= PH_PREFIX;
         units_ff    <= '0;
         pre_ff      <= PRE_NONE;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_unit_limit;
         end
         if (accept) begin
            if (end_of_buffer) begin
               hist_ff     <= '0;
               hist_cnt_ff <= 2'd0;
               pos_ff      <= '0;
               start_ff    <= '0;
               phase_ff    <= PH_PREFIX;
               units_ff    <= '0;
               pre_ff      <= PRE_NONE;
            end else begin
               hist_ff     <= hist_in;
               hist_cnt_ff <= hist_cnt_in;
               pos_ff      <= pos_in;
               start_ff    <= start_in;
               phase_ff    <= phase_in;
               units_ff    <= units_in;
               pre_ff      <= pre_in;
            end
         end
      end
   end

endmodule

### design/anbs_fifo.sv
// Result item queue: up to two writes and one read per cycle.
module anbs_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  anbs_pkg::push_type        push,
   input  logic                      pop,
   output anbs_pkg::result_type      head,
   output anbs_pkg::fifo_status_type status
);
   import anbs_pkg::*;

   result_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_IDX_W-1:0] wr_next;

   assign wr_next   = wr_ptr_ff + FIFO_IDX_W'(1);
   assign wr_ptr_in = wr_ptr_ff + FIFO_IDX_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_IDX_W'(pop);
   assign count_in  = count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);

   assign head               = mem_ff[rd_ptr_ff];
   assign status.nonempty    = count_ff != '0;
   assign status.almost_full = count_ff > FIFO_CNT_W'(FIFO_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/anbs_out.sv
// Back end: output register that drains the queue onto the result channel.
module anbs_out (
   input  logic                      clock,
   input  logic                      reset,
   input  anbs_pkg::result_type      head,
   input  anbs_pkg::fifo_status_type status,
   input  logic                      rsp_stall,
   output logic                      pop,
   output logic                      rsp_valid,
   output anbs_pkg::result_type      rsp_item
);
   import anbs_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_item_ff;
   logic       open;

   assign open         = !rsp_valid_ff || !rsp_stall;
   assign pop          = open && status.nonempty;
   assign rsp_valid_in = open ? status.nonempty : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_item_ff <= head;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### sim/nal_split_checker.sv
// Checker for the NAL unit splitter: predicts result items from accepted bytes and compares them.
`timescale 1ns / 100ps
module nal_split_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [anbs_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                              req_end_of_buffer,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [anbs_pkg::OFFSET_W-1:0]     rsp_unit_offset,
   input  logic [anbs_pkg::SIZE_W-1:0]       rsp_unit_size,
   input  logic [anbs_pkg::PREFIX_W-1:0]     rsp_prefix_length,
   input  logic                              rsp_last_unit,
   input  logic                              rsp_limit_hit,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [anbs_pkg::LIMIT_W-1:0]      csr_unit_limit,
   output int                                pending,
   output int                                bytes_taken,
   output int                                fail_count
);
   import anbs_pkg::*;

   typedef enum logic [1:0] {AT_UNIT_START, IN_PAYLOAD, BUFFER_DONE} scan_state_type;

   logic [BYTE_W-1:0]   win [4];
   int                  win_count;
   logic [POS_W-1:0]    position;
   logic [POS_W-1:0]    open_start;
   logic [PREFIX_W-1:0] open_prefix;
   scan_state_type      scan_state;
   logic [LIMIT_W-1:0]  units_done;
   logic [LIMIT_W-1:0]  limit_value;
   result_type          unit_queue [$];
   result_type          want;

   task report_mismatch(input string note);
      $display("mismatch at %0t: %s", $time, note);
      fail_count++;
   endtask

   function void clear_buffer();
      win_count = 0;
      position = '0;
      open_start = '0;
      open_prefix = PRE_NONE;
      scan_state = AT_UNIT_START;
      units_done = '0;
   endfunction

   function void drop_front(int k);
      for (int i = 0; i + k < 4; i++) begin
         win[i] = win[i + k];
      end
      win_count -= k;
   endfunction

   function void open_unit(logic [PREFIX_W-1:0] code);
      open_start = position - POS_W'(win_count);
      open_prefix = code;
      scan_state = IN_PAYLOAD;
   endfunction

   function void queue_unit(logic [OFFSET_W-1:0] offset, logic [SIZE_W-1:0] size,
                            logic [PREFIX_W-1:0] code, logic last, logic hit);
      result_type r;
      r.unit_offset = offset;
      r.unit_size = size;
      r.prefix_length = code;
      r.last_unit = last;
      r.limit_hit = hit;
      unit_queue.push_back(r);
   endfunction

   task predict_byte(input logic [BYTE_W-1:0] data, input logic eob);
      logic             scanning;
      logic             at_limit;
      logic [POS_W-1:0] end_pos;
      if (scan_state != BUFFER_DONE && units_done >= limit_value) begin
         scan_state = BUFFER_DONE;
         win_count = 0;
      end
      if (scan_state != BUFFER_DONE && position < MAX_BUFFER_BYTES) begin
         win[win_count] = data;
         win_count++;
         position++;
         scanning = 1'b1;
         while (scanning) begin
            if (scan_state == AT_UNIT_START) begin
               if ((win_count >= 1 && win[0] != 8'h00) || (win_count >= 2 && win[1] != 8'h00)) begin
                  open_unit(PRE_NONE);
               end else if (win_count < 3) begin
                  scanning = 1'b0;
               end else if (win[2] == 8'h01) begin
                  drop_front(3);
                  open_unit(PRE_THREE);
               end else if (win[2] > 8'h01) begin
                  open_unit(PRE_NONE);
               end else if (win_count < 4) begin
                  scanning = 1'b0;
               end else if (win[3] == 8'h01) begin
                  drop_front(4);
                  open_unit(PRE_FOUR);
               end else begin
                  // zero run ahead of a start code: skip one zero and look again
                  drop_front(1);
               end
            end else if (scan_state == IN_PAYLOAD) begin
               if (win_count < 3) begin
                  scanning = 1'b0;
               end else if (win[0] == 8'h00 && win[1] == 8'h00 && win[2] <= 8'h01) begin
                  end_pos = position - POS_W'(win_count);
                  at_limit = ({1'b0, units_done} + 9'd1) >= {1'b0, limit_value};
                  queue_unit(open_start[OFFSET_W-1:0], end_pos - open_start, open_prefix,
                             at_limit, at_limit);
                  units_done++;
                  if (at_limit) begin
                     scan_state = BUFFER_DONE;
                     win_count = 0;
                     scanning = 1'b0;
                  end else begin
                     scan_state = AT_UNIT_START;
                  end
               end else begin
                  drop_front(1);
               end
            end else begin
               win_count = 0;
               scanning = 1'b0;
            end
         end
      end
      if (eob) begin
         end_pos = position;
         if (scan_state == AT_UNIT_START && win_count == 3) begin
            queue_unit(OFFSET_W'(end_pos - POS_W'(2)), SIZE_W'(2), PRE_NONE, 1'b1, 1'b0);
         end else if (scan_state == AT_UNIT_START && win_count > 0) begin
            queue_unit(OFFSET_W'(end_pos - POS_W'(win_count)), SIZE_W'(win_count), PRE_NONE,
                       1'b1, 1'b0);
         end else if (scan_state == IN_PAYLOAD) begin
            queue_unit(open_start[OFFSET_W-1:0], end_pos - open_start, open_prefix, 1'b1, 1'b0);
         end
         clear_buffer();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_buffer();
         limit_value = LIMIT_RESET;
         unit_queue.delete();
         fail_count = 0;
         bytes_taken <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            limit_value = csr_unit_limit;
         end
         if (req_valid && !req_stall) begin
            bytes_taken <= bytes_taken + 1;
            predict_byte(req_data_byte, req_end_of_buffer);
         end
         if (rsp_valid && !rsp_stall) begin
            if (unit_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected unit off %0d size %0d", rsp_unit_offset,
                                         rsp_unit_size));
            end else begin
               want = unit_queue.pop_front();
               if (rsp_unit_offset !== want.unit_offset || rsp_unit_size !== want.unit_size ||
                   rsp_prefix_length !== want.prefix_length ||
                   rsp_last_unit !== want.last_unit || rsp_limit_hit !== want.limit_hit) begin
                  report_mismatch($sformatf(
                     "got off %0d size %0d pre %0d last %b hit %b, want %0d %0d %0d %b %b",
                     rsp_unit_offset, rsp_unit_size, rsp_prefix_length, rsp_last_unit,
                     rsp_limit_hit, want.unit_offset, want.unit_size, want.prefix_length,
                     want.last_unit, want.limit_hit));
               end
            end
         end
      end
      pending <= unit_queue.size();
   end

endmodule

### sim/testbench.sv
// Testbench top for the NAL unit splitter: clock, reset, byte stream stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
   import anbs_pkg::*;

   localparam int RANDOM_BYTES  = 1950;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 6;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                req_end_of_buffer = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [OFFSET_W-1:0] rsp_unit_offset;
   logic [SIZE_W-1:0]   rsp_unit_size;
   logic [PREFIX_W-1:0] rsp_prefix_length;
   logic                rsp_last_unit;
   logic                rsp_limit_hit;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [LIMIT_W-1:0]  csr_unit_limit = LIMIT_RESET;

   int pending;
   int bytes_taken;
   int fail_count;
   int cycle_count = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int random_base;

   logic [BYTE_W-1:0] pile [$];

   annexb_nal_unit_splitter u_top (.*);

   nal_split_checker u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver back-pressure: modes from never to mostly stalled
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left <= $urandom_range(20, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ($urandom_range(0, 15) < 12);
      endcase
   end

   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic eob);
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_end_of_buffer <= eob;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 24);
      end
   endtask

   task automatic send_pile(input logic close);
      for (int i = 0; i < pile.size(); i++) begin
         send_byte(pile[i], close && (i == pile.size() - 1));
      end
      pile.delete();
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_unit_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic build_stream();
      int units;
      int kind;
      int len;
      logic [BYTE_W-1:0] b;
      units = $urandom_range(1, 6);
      for (int u = 0; u < units; u++) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            pile.push_back(8'h00); pile.push_back(8'h00); pile.push_back(8'h01);
         end else if (kind < 7) begin
            pile.push_back(8'h00); pile.push_back(8'h00); pile.push_back(8'h00);
            pile.push_back(8'h01);
         end else if (kind == 7) begin
            pile.push_back(8'h00); pile.push_back(8'h00); pile.push_back(8'h00);
            pile.push_back(8'h00); pile.push_back(8'h01);
         end else if (kind == 9) begin
            repeat ($urandom_range(1, 2)) pile.push_back(8'h00);
         end
         len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
         for (int j = 0; j < len; j++) begin
            if (j == 0) b = BYTE_W'($urandom_range(1, 255));
            else b = BYTE_W'(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 255));
            pile.push_back(b);
         end
      end
      case ($urandom_range(0, 7))
         0: begin
            pile.push_back(8'h00); pile.push_back(8'h00); pile.push_back(8'h01);
         end
         1: begin
            pile.push_back(8'h00); pile.push_back(8'h00); pile.push_back(8'h00);
         end
         2: pile.push_back(8'h00);
         default: ;
      endcase
      if (pile.size() == 0) pile.push_back(BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic build_noise();
      int r;
      repeat ($urandom_range(1, 16)) begin
         r = $urandom_range(0, 19);
         if (r < 8) pile.push_back(8'h00);
         else if (r < 11) pile.push_back(8'h01);
         else pile.push_back(BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // four-byte code, then a start code right at the buffer end
      pile = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01};
      send_pile(1'b1);
      // buffer of only zeros at a unit start
      pile = '{8'h00, 8'h00, 8'h00};
      send_pile(1'b1);
      // no start code at all
      pile = '{8'h80};
      send_pile(1'b1);
      // limit lowered to the count already reported, mid buffer
      pile = '{8'h00, 8'h00, 8'h01, 8'h41, 8'h00, 8'h00, 8'h01};
      send_pile(1'b0);
      wait_idle();
      write_limit(8'd1);
      pile = '{8'h42};
      send_pile(1'b1);
      // limit reached on a terminator, rest ignored
      pile = '{8'h55, 8'h00, 8'h00, 8'h01, 8'h66, 8'hFF};
      send_pile(1'b1);
      wait_idle();
      write_limit(8'd255);

      random_base = bytes_taken;
      while (bytes_taken - random_base < RANDOM_BYTES) begin
         if ($urandom_range(0, 11) == 0) begin
            wait_idle();
            case ($urandom_range(0, 5))
               0: write_limit(8'd1);
               1: write_limit(8'd255);
               2: write_limit(8'd2);
               3: write_limit(8'd3);
               default: write_limit(LIMIT_W'($urandom_range(1, 255)));
            endcase
         end
         if ($urandom_range(0, 4) == 0) build_noise();
         else build_stream();
         send_pile(1'b1);
      end
      wait_idle();

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
